// ===== hdl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers shared by the walker RTL.
// No dependencies; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define GRW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("grw: assertion failed");

// condition must never be seen outside reset
`define GRW_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("grw: forbidden condition seen");

`endif

// ===== hdl/grw_pkg.sv =====
// grw_pkg: types, constants and small helpers of the grid ray cell walker.
// No dependencies; used by every module of the block except grw_fifo.
package grw_pkg;

    // field widths
    localparam int ORIGIN_W      = 24;
    localparam int DIR_W         = 16;
    localparam int DIST_W        = 32;
    localparam int CELL_OUT_W    = 6;
    localparam int AXIS_W        = 2;
    localparam int CELL_SIZE_W   = 16;
    localparam int MAX_CELLS_W   = 7;
    localparam int FRAC_SHIFT    = 15;
    localparam int SIZE_SHIFT    = 4;
    localparam int SIZE16_W      = CELL_SIZE_W + SIZE_SHIFT;

    // stream and config port widths
    localparam int IN_TDATA_W    = 2 * ORIGIN_W + 2 * DIR_W;
    localparam int OUT_FIELDS_W  = 2 * CELL_OUT_W + DIST_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 16;

    // divider
    localparam int DIV_NUM_W     = SIZE16_W + FRAC_SHIFT;
    localparam int DIV_DEN_W     = SIZE16_W;
    localparam int DIV_CNT_W     = $clog2(DIV_NUM_W + 1);

    localparam int MAX_RESULTS   = 64;

    typedef logic [DIV_NUM_W-1:0] num_t;
    typedef logic [DIV_DEN_W-1:0] den_t;
    typedef logic [DIST_W-1:0]    dist_t;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_SIZE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CELLS = 4'd1;

    localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RESET = 16'd12288;
    localparam logic [MAX_CELLS_W-1:0] MAX_CELLS_RESET = 7'd32;

    // crossed axis codes
    localparam logic [AXIS_W-1:0] AXIS_START = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_X     = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd2;

    // setup operation: bit 2 selects the axis, bits 1:0 the step
    localparam logic [1:0] STEP_ORIGIN = 2'd0;
    localparam logic [1:0] STEP_WRAP   = 2'd1;
    localparam logic [1:0] STEP_BOUND  = 2'd2;
    localparam logic [1:0] STEP_SPAN   = 2'd3;
    localparam logic [2:0] OP_LAST     = 3'b111;

    typedef struct packed {
        logic [DIR_W-1:0]    dir_y;
        logic [DIR_W-1:0]    dir_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [ORIGIN_W-1:0] origin_x;
    } ray_t;

    typedef struct packed {
        dist_t                  tmax_x;
        dist_t                  tmax_y;
        dist_t                  span_x;
        dist_t                  span_y;
        logic                   neg_x;
        logic                   neg_y;
        logic [MAX_CELLS_W-1:0] count;
    } setup_t;

    typedef struct packed {
        logic start;
        num_t dividend;
        den_t divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        num_t quotient;
        den_t remainder;
    } div_rsp_t;

    function automatic dist_t sat_quo(input num_t q);
        return (|q[DIV_NUM_W-1:DIST_W]) ? '1 : q[DIST_W-1:0];
    endfunction

    function automatic dist_t sat_add(input dist_t a, input dist_t b);
        logic [DIST_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DIST_W] ? '1 : sum[DIST_W-1:0];
    endfunction

    function automatic logic [MAX_CELLS_W-1:0] clamp_count(
        input logic [MAX_CELLS_W-1:0] mc
    );
        logic [MAX_CELLS_W-1:0] n;
        n = mc;
        if (mc == '0)
        begin
            n = MAX_CELLS_W'(1);
        end
        else if (mc > MAX_CELLS_W'(MAX_RESULTS))
        begin
            n = MAX_CELLS_W'(MAX_RESULTS);
        end
        return n;
    endfunction

endpackage

// ===== hdl/grid_ray_cell_walker.sv =====
// grid_ray_cell_walker: top level; config registers, setup front end,
// record queue and cell walker. Depends on grw_pkg and all grw_* modules.
//
// Takes one ray per request and emits max_cells cells (clamped to 1..64) for
// it, one cell per cycle while the output is taken. Ray setup runs six
// divisions (cell index, first boundary and cell span, per axis) on one
// shared restoring divider that retires one quotient bit per cycle, and
// reduces each cell index modulo MAP_SIZE by a reciprocal multiply; a new
// ray is taken only after the setup of the last one has handed its record
// to the queue. The walk of one ray overlaps the setup of the next through
// a queue of QUEUE_DEPTH records. The first cell of a ray is valid once its
// record has passed the queue and the walker's output register.
// Configuration writes are accepted in every cycle.
module grid_ray_cell_walker #(
    parameter int MAP_SIZE    = 64,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // ray stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: origin_x[23:0], origin_y[47:24], dir_x[63:48], dir_y[79:64]
    input  logic [grw_pkg::IN_TDATA_W-1:0]    s_tdata,
    // cell stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: cell_x[5:0], cell_y[11:6], entry_distance[43:12], zero[47:44]
    output logic [grw_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // tuser: crossed_axis[1:0]
    output logic [grw_pkg::AXIS_W-1:0]        m_tuser,
    output logic                              m_tlast,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [grw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [grw_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CELL_W = $clog2(MAP_SIZE);
    localparam int REC_W  = $bits(grw_pkg::setup_t) + 2 * CELL_W;

    logic [grw_pkg::CELL_SIZE_W-1:0] cell_size_reg;
    logic [grw_pkg::MAX_CELLS_W-1:0] max_cells_reg;

    grw_pkg::ray_t      ray;
    grw_pkg::div_req_t  div_req;
    grw_pkg::div_rsp_t  div_rsp;

    logic               front_valid, front_ready;
    grw_pkg::setup_t    front_rec;
    logic [CELL_W-1:0]  front_cell_x, front_cell_y;
    logic [REC_W-1:0]   q_push_data, q_pop_data;

    logic               back_valid, back_ready;
    grw_pkg::setup_t    back_rec;
    logic [CELL_W-1:0]  back_cell_x, back_cell_y;

    logic [CELL_W-1:0]              walk_cell_x, walk_cell_y;
    grw_pkg::dist_t                 walk_entry;
    logic [CELL_W+grw_pkg::CELL_OUT_W-1:0] cx_wide, cy_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= grw_pkg::CELL_SIZE_RESET;
            max_cells_reg <= grw_pkg::MAX_CELLS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                grw_pkg::REG_CELL_SIZE:
                begin
                    cell_size_reg <= cfg_data;
                end
                grw_pkg::REG_MAX_CELLS:
                begin
                    max_cells_reg <= cfg_data[grw_pkg::MAX_CELLS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        ray.origin_x = s_tdata[grw_pkg::ORIGIN_W-1:0];
        ray.origin_y = s_tdata[2*grw_pkg::ORIGIN_W-1:grw_pkg::ORIGIN_W];
        ray.dir_x    = s_tdata[2*grw_pkg::ORIGIN_W+grw_pkg::DIR_W-1:2*grw_pkg::ORIGIN_W];
        ray.dir_y    = s_tdata[grw_pkg::IN_TDATA_W-1:2*grw_pkg::ORIGIN_W+grw_pkg::DIR_W];
    end

    grw_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    grw_setup #(
        .MAP_SIZE (MAP_SIZE)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .ray_valid  (s_tvalid),
        .ray_ready  (s_tready),
        .ray        (ray),
        .cell_size  (cell_size_reg),
        .max_cells  (max_cells_reg),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .rec_valid  (front_valid),
        .rec_ready  (front_ready),
        .rec        (front_rec),
        .rec_cell_x (front_cell_x),
        .rec_cell_y (front_cell_y)
    );

    assign q_push_data = {front_cell_y, front_cell_x, front_rec};

    grw_fifo #(
        .DATA_W (REC_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (q_push_data),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (q_pop_data)
    );

    assign {back_cell_y, back_cell_x, back_rec} = q_pop_data;

    grw_walk #(
        .MAP_SIZE (MAP_SIZE)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (back_valid),
        .rec_ready  (back_ready),
        .rec        (back_rec),
        .rec_cell_x (back_cell_x),
        .rec_cell_y (back_cell_y),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_cell_x (walk_cell_x),
        .out_cell_y (walk_cell_y),
        .out_axis   (m_tuser),
        .out_entry  (walk_entry),
        .out_last   (m_tlast)
    );

    // only the low six bits of a cell index leave the block
    assign cx_wide = {{grw_pkg::CELL_OUT_W{1'b0}}, walk_cell_x};
    assign cy_wide = {{grw_pkg::CELL_OUT_W{1'b0}}, walk_cell_y};

    assign m_tdata = {{grw_pkg::OUT_PAD_W{1'b0}}, walk_entry,
                      cy_wide[grw_pkg::CELL_OUT_W-1:0], cx_wide[grw_pkg::CELL_OUT_W-1:0]};

endmodule

// ===== hdl/grw_div.sv =====
// grw_div: restoring divider, one quotient bit per cycle.
// Depends on grw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module grw_div (
    input  logic              clk,
    input  logic              rst_n,
    input  grw_pkg::div_req_t req,
    output grw_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [grw_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    grw_pkg::num_t                 quo_reg;
    grw_pkg::den_t                 rem_reg;
    grw_pkg::den_t                 den_reg;
    logic [grw_pkg::DIV_DEN_W:0]   trial;
    logic [grw_pkg::DIV_DEN_W:0]   diff;
    logic                          fits;
    logic                          load;

    assign load = req.start && !busy_reg;

    always_comb
    begin
        trial = {rem_reg, quo_reg[grw_pkg::DIV_NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = grw_pkg::DIV_CNT_W'(grw_pkg::DIV_NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == grw_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // zero divisor yields an all-ones quotient, which saturates downstream
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[grw_pkg::DIV_NUM_W-2:0], fits};
            rem_reg <= fits ? diff[grw_pkg::DIV_DEN_W-1:0] : trial[grw_pkg::DIV_DEN_W-1:0];
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    `GRW_ASSERT(a_div_busy_count, clk, rst_n, busy_reg |-> (cnt_reg != '0))

endmodule

// ===== hdl/grw_setup.sv =====
// grw_setup: front end; takes one ray, runs its six divisions on the
// shared divider and hands a walk record to the queue.
// Depends on grw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module grw_setup #(
    parameter int   MAP_SIZE = 64,
    localparam int  CELL_W   = $clog2(MAP_SIZE)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             ray_valid,
    output logic                             ray_ready,
    input  grw_pkg::ray_t                    ray,
    input  logic [grw_pkg::CELL_SIZE_W-1:0]  cell_size,
    input  logic [grw_pkg::MAX_CELLS_W-1:0]  max_cells,
    output grw_pkg::div_req_t                div_req,
    input  grw_pkg::div_rsp_t                div_rsp,
    output logic                             rec_valid,
    input  logic                             rec_ready,
    output grw_pkg::setup_t                  rec,
    output logic [CELL_W-1:0]                rec_cell_x,
    output logic [CELL_W-1:0]                rec_cell_y
);

    // cell index modulo MAP_SIZE by reciprocal multiplication; exact for
    // every index of DIV_DEN_W bits
    localparam int MOD_SHIFT = grw_pkg::DIV_DEN_W + CELL_W;
    localparam int RECIP_W   = grw_pkg::DIV_DEN_W + 2;
    localparam int PROD_W    = grw_pkg::DIV_DEN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MOD_RECIP =
        RECIP_W'(((64'd1 << MOD_SHIFT) + 64'(MAP_SIZE) - 64'd1) / 64'(MAP_SIZE));

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ISSUE = 6'b000010,
        S_WAIT  = 6'b000100,
        S_MUL   = 6'b001000,
        S_MOD   = 6'b010000,
        S_PUSH  = 6'b100000
    } fstate_t;

    fstate_t                          state_reg, state_next;
    logic [2:0]                       op_reg, op_next;
    logic                             accept;
    logic                             capture;

    grw_pkg::ray_t                    ray_reg;
    grw_pkg::den_t                    size16_reg;
    logic [grw_pkg::MAX_CELLS_W-1:0]  count_reg;
    grw_pkg::den_t                    quo_reg;
    grw_pkg::den_t                    rem_reg;
    logic [CELL_W-1:0]                cell_x_reg;
    logic [CELL_W-1:0]                cell_y_reg;
    grw_pkg::dist_t                   tmax_x_reg, tmax_y_reg;
    grw_pkg::dist_t                   span_x_reg, span_y_reg;
    logic [PROD_W-1:0]                prod_reg;

    logic [grw_pkg::CELL_SIZE_W-1:0]  size_eff;
    logic [grw_pkg::ORIGIN_W-1:0]     origin;
    logic [grw_pkg::DIR_W-1:0]        dir;
    logic [grw_pkg::DIR_W-1:0]        mag;
    logic                             neg;
    grw_pkg::den_t                    bnd_gap;
    grw_pkg::dist_t                   sat_q;
    grw_pkg::den_t                    wrap_quo;
    grw_pkg::den_t                    wrap_cell;

    assign ray_ready = (state_reg == S_IDLE);
    assign rec_valid = (state_reg == S_PUSH);
    assign size_eff  = (cell_size == '0) ? grw_pkg::CELL_SIZE_W'(1) : cell_size;
    assign sat_q     = grw_pkg::sat_quo(div_rsp.quotient);

    always_comb
    begin
        wrap_quo  = grw_pkg::den_t'(prod_reg[PROD_W-1:MOD_SHIFT]);
        wrap_cell = quo_reg - wrap_quo * grw_pkg::den_t'(MAP_SIZE);
    end

    // operand selection for the current operation
    always_comb
    begin
        origin  = op_reg[2] ? ray_reg.origin_y : ray_reg.origin_x;
        dir     = op_reg[2] ? ray_reg.dir_y : ray_reg.dir_x;
        neg     = dir[grw_pkg::DIR_W-1];
        mag     = neg ? (grw_pkg::DIR_W'(0) - dir) : dir;
        bnd_gap = neg ? rem_reg : (size16_reg - rem_reg);
        case (op_reg[1:0])
            grw_pkg::STEP_ORIGIN:
            begin
                div_req.dividend = grw_pkg::num_t'(origin);
                div_req.divisor  = size16_reg;
            end
            grw_pkg::STEP_BOUND:
            begin
                div_req.dividend = {bnd_gap, grw_pkg::FRAC_SHIFT'(0)};
                div_req.divisor  = grw_pkg::den_t'(mag);
            end
            default:
            begin
                div_req.dividend = {size16_reg, grw_pkg::FRAC_SHIFT'(0)};
                div_req.divisor  = grw_pkg::den_t'(mag);
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        accept        = 1'b0;
        capture       = 1'b0;
        div_req.start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (ray_valid)
                begin
                    accept     = 1'b1;
                    op_next    = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                div_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    capture = 1'b1;
                    if (op_reg == grw_pkg::OP_LAST)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        op_next = op_reg + 3'd1;
                        if (op_reg[1:0] == grw_pkg::STEP_ORIGIN)
                        begin
                            state_next = S_MUL;
                        end
                        else
                        begin
                            state_next = S_ISSUE;
                        end
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                op_next    = op_reg + 3'd1;
                state_next = S_ISSUE;
            end
            S_PUSH:
            begin
                if (rec_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ray_reg    <= ray;
            size16_reg <= {size_eff, grw_pkg::SIZE_SHIFT'(0)};
            count_reg  <= grw_pkg::clamp_count(max_cells);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(quo_reg) * PROD_W'(MOD_RECIP);
        end
        if (state_reg == S_MOD)
        begin
            if (op_reg[2])
            begin
                cell_y_reg <= wrap_cell[CELL_W-1:0];
            end
            else
            begin
                cell_x_reg <= wrap_cell[CELL_W-1:0];
            end
        end
        if (capture)
        begin
            case (op_reg[1:0])
                grw_pkg::STEP_ORIGIN:
                begin
                    quo_reg <= div_rsp.quotient[grw_pkg::DIV_DEN_W-1:0];
                    rem_reg <= div_rsp.remainder;
                end
                grw_pkg::STEP_BOUND:
                begin
                    if (op_reg[2])
                    begin
                        tmax_y_reg <= sat_q;
                    end
                    else
                    begin
                        tmax_x_reg <= sat_q;
                    end
                end
                default:
                begin
                    if (op_reg[2])
                    begin
                        span_y_reg <= sat_q;
                    end
                    else
                    begin
                        span_x_reg <= sat_q;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        rec.tmax_x = tmax_x_reg;
        rec.tmax_y = tmax_y_reg;
        rec.span_x = span_x_reg;
        rec.span_y = span_y_reg;
        rec.neg_x  = ray_reg.dir_x[grw_pkg::DIR_W-1];
        rec.neg_y  = ray_reg.dir_y[grw_pkg::DIR_W-1];
        rec.count  = count_reg;
    end

    assign rec_cell_x = cell_x_reg;
    assign rec_cell_y = cell_y_reg;

    `GRW_ASSERT(a_issue_div_idle, clk, rst_n, (state_reg == S_ISSUE) |-> !div_rsp.busy)
    `GRW_ASSERT(a_done_in_wait, clk, rst_n, div_rsp.done |-> (state_reg == S_WAIT))

endmodule

// ===== hdl/grw_fifo.sv =====
// grw_fifo: small first-word-fall-through queue of walk records between
// the setup front end and the walker. Depends on assert_macros.svh.
`include "assert_macros.svh"

module grw_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `GRW_ASSERT(a_fifo_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH))

endmodule

// ===== hdl/grw_walk.sv =====
// grw_walk: back end; pops a walk record and emits one cell per cycle, while
// the output is taken, through an output register. Depends on grw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module grw_walk #(
    parameter int   MAP_SIZE = 64,
    localparam int  CELL_W   = $clog2(MAP_SIZE)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rec_valid,
    output logic                     rec_ready,
    input  grw_pkg::setup_t          rec,
    input  logic [CELL_W-1:0]        rec_cell_x,
    input  logic [CELL_W-1:0]        rec_cell_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CELL_W-1:0]        out_cell_x,
    output logic [CELL_W-1:0]        out_cell_y,
    output logic [grw_pkg::AXIS_W-1:0] out_axis,
    output grw_pkg::dist_t           out_entry,
    output logic                     out_last
);

    localparam logic [CELL_W-1:0] CELL_TOP = CELL_W'(MAP_SIZE - 1);

    logic                             active_reg, active_next;
    logic [grw_pkg::MAX_CELLS_W-1:0]  left_reg, left_next;
    logic                             out_valid_reg, out_valid_next;

    logic [CELL_W-1:0]                cx_reg, cy_reg;
    grw_pkg::dist_t                   tmx_reg, tmy_reg;
    grw_pkg::dist_t                   tdx_reg, tdy_reg;
    logic                             negx_reg, negy_reg;

    logic [CELL_W-1:0]                out_cell_x_reg, out_cell_y_reg;
    logic [grw_pkg::AXIS_W-1:0]       out_axis_reg;
    grw_pkg::dist_t                   out_entry_reg;
    logic                             out_last_reg;

    logic                             load;
    logic                             pop;
    logic                             step;
    logic                             step_x;
    logic [CELL_W-1:0]                cx_stepped, cy_stepped;

    assign load      = !out_valid_reg || out_ready;
    assign rec_ready = load && !active_reg;
    assign pop       = rec_ready && rec_valid;
    assign step      = load && active_reg;
    // ties go to y
    assign step_x    = tmx_reg < tmy_reg;

    always_comb
    begin
        if (negx_reg)
        begin
            cx_stepped = (cx_reg == '0) ? CELL_TOP : cx_reg - 1'b1;
        end
        else
        begin
            cx_stepped = (cx_reg == CELL_TOP) ? '0 : cx_reg + 1'b1;
        end
        if (negy_reg)
        begin
            cy_stepped = (cy_reg == '0) ? CELL_TOP : cy_reg - 1'b1;
        end
        else
        begin
            cy_stepped = (cy_reg == CELL_TOP) ? '0 : cy_reg + 1'b1;
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = pop || step;
        end
        if (pop)
        begin
            left_next   = rec.count - 1'b1;
            active_next = (rec.count != grw_pkg::MAX_CELLS_W'(1));
        end
        else if (step)
        begin
            left_next   = left_reg - 1'b1;
            active_next = (left_reg != grw_pkg::MAX_CELLS_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cx_reg         <= rec_cell_x;
            cy_reg         <= rec_cell_y;
            tmx_reg        <= rec.tmax_x;
            tmy_reg        <= rec.tmax_y;
            tdx_reg        <= rec.span_x;
            tdy_reg        <= rec.span_y;
            negx_reg       <= rec.neg_x;
            negy_reg       <= rec.neg_y;
            out_cell_x_reg <= rec_cell_x;
            out_cell_y_reg <= rec_cell_y;
            out_axis_reg   <= grw_pkg::AXIS_START;
            out_entry_reg  <= '0;
            out_last_reg   <= (rec.count == grw_pkg::MAX_CELLS_W'(1));
        end
        else if (step)
        begin
            out_last_reg <= (left_reg == grw_pkg::MAX_CELLS_W'(1));
            if (step_x)
            begin
                cx_reg         <= cx_stepped;
                tmx_reg        <= grw_pkg::sat_add(tmx_reg, tdx_reg);
                out_cell_x_reg <= cx_stepped;
                out_cell_y_reg <= cy_reg;
                out_axis_reg   <= grw_pkg::AXIS_X;
                out_entry_reg  <= tmx_reg;
            end
            else
            begin
                cy_reg         <= cy_stepped;
                tmy_reg        <= grw_pkg::sat_add(tmy_reg, tdy_reg);
                out_cell_x_reg <= cx_reg;
                out_cell_y_reg <= cy_stepped;
                out_axis_reg   <= grw_pkg::AXIS_Y;
                out_entry_reg  <= tmy_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_cell_x = out_cell_x_reg;
    assign out_cell_y = out_cell_y_reg;
    assign out_axis   = out_axis_reg;
    assign out_entry  = out_entry_reg;
    assign out_last   = out_last_reg;

    `GRW_ASSERT(a_walk_left_nonzero, clk, rst_n, active_reg |-> (left_reg != '0))
    `GRW_ASSERT(a_walk_left_range, clk, rst_n,
        left_reg < grw_pkg::MAX_CELLS_W'(grw_pkg::MAX_RESULTS))

endmodule
